@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/thlr_pkg.sv @@
`default_nettype none
package thlr_pkg;

	localparam int COORD_BITS_DEF    = 13;
	localparam int MAX_THICKNESS_DEF = 16;

	localparam int THK_W   = 5;
	localparam int FRAME_W = 13;
	localparam int PIX_W   = 12;
	localparam int COLOR_W = 8;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 2;

	localparam logic [THK_W-1:0]   THK_RESET   = THK_W'(1);
	localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(512);
	localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(4096);

	typedef enum logic [IDX_W-1:0] {
		REG_LINE_THICKNESS = 2'd0,
		REG_FRAME_WIDTH    = 2'd1,
		REG_FRAME_HEIGHT   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

endpackage
`default_nettype wire

@@ rtl/thick_line_rasterizer_core.sv @@
// thick line rasterizer: bresenham walk with a square brush per line point
// a tick request's pixel write is registered and shows in the cycle after acceptance
// throughput: one request per cycle while in_stall is low; the line step, brush
//   offset and frame clip settle between the state and output registers
// reset: arst_n clears line activity, brush counters and the output valid,
//   and loads thickness 1 and a 512 x 512 frame
`default_nettype none
`include "assert_macros.svh"
module thick_line_rasterizer_core #(
	parameter int COORD_BITS    = thlr_pkg::COORD_BITS_DEF,
	parameter int MAX_THICKNESS = thlr_pkg::MAX_THICKNESS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration writes
	input  wire logic                            cfg_wr_en,
	input  wire logic [thlr_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [thlr_pkg::CFG_W-1:0]      cfg_wr_data,
	// request channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            opcode,
	input  wire logic signed [COORD_BITS-1:0]    x_start,
	input  wire logic signed [COORD_BITS-1:0]    y_start,
	input  wire logic signed [COORD_BITS-1:0]    x_end,
	input  wire logic signed [COORD_BITS-1:0]    y_end,
	input  wire logic [thlr_pkg::COLOR_W-1:0]    color_red,
	input  wire logic [thlr_pkg::COLOR_W-1:0]    color_green,
	input  wire logic [thlr_pkg::COLOR_W-1:0]    color_blue,
	// pixel write channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [thlr_pkg::PIX_W-1:0]           pixel_x,
	output logic [thlr_pkg::PIX_W-1:0]           pixel_y,
	output logic [thlr_pkg::COLOR_W-1:0]         out_red,
	output logic [thlr_pkg::COLOR_W-1:0]         out_green,
	output logic [thlr_pkg::COLOR_W-1:0]         out_blue,
	output logic                                 last_pixel
);
	import thlr_pkg::*;

	// brush counter width, clamped thickness width, delta / error / pixel widths
	localparam int OFS_W = (MAX_THICKNESS > 1) ? $clog2(MAX_THICKNESS) : 1;
	localparam int TB    = $clog2(MAX_THICKNESS + 1);
	localparam int TW    = ((TB > THK_W) ? TB : THK_W) + 1;
	localparam int DW    = COORD_BITS + 1;
	localparam int EW    = COORD_BITS + 2;
	localparam int PW    = (COORD_BITS + 2 > FRAME_W + 1) ? COORD_BITS + 2 : FRAME_W + 1;

	// configuration registers
	logic [THK_W-1:0]   thk_q;
	logic [FRAME_W-1:0] fw_q;
	logic [FRAME_W-1:0] fh_q;

	// line state
	logic                         active_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic signed [DW-1:0]         dx_q, ndy_q;
	logic                         sx_q, sy_q;
	logic signed [EW-1:0]         err_q;
	logic [OFS_W-1:0]             blk_x_q, blk_y_q;
	logic [COLOR_W-1:0]           red_q, green_q, blue_q;

	// output register
	logic                         out_valid_q;
	logic [PIX_W-1:0]             pixel_x_q, pixel_y_q;
	logic [COLOR_W-1:0]           out_red_q, out_green_q, out_blue_q;
	logic                         last_q;

	logic in_acc;
	logic is_start;

	// the output slot frees when it is empty or being taken this cycle
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign is_start = (opcode == OP_START);

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thk_q <= THK_RESET;
			fw_q  <= FRAME_RESET;
			fh_q  <= FRAME_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_THICKNESS: thk_q <= cfg_wr_data[THK_W-1:0];
				REG_FRAME_WIDTH:    fw_q  <= cfg_wr_data[FRAME_W-1:0];
				REG_FRAME_HEIGHT:   fh_q  <= cfg_wr_data[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- brush geometry
	logic [TW-1:0] thk_raw, t_eff, half;
	logic          row_end, blk_end;

	always_comb begin
		thk_raw = TW'(thk_q);
		// zero acts as one, anything past the brush limit as the limit
		if (thk_raw == '0)
			t_eff = TW'(1);
		else if (thk_raw > TW'(MAX_THICKNESS))
			t_eff = TW'(MAX_THICKNESS);
		else
			t_eff = thk_raw;
		half    = t_eff >> 1;
		// counters left beyond a shrunk side end their row or block at once
		row_end = (TW'(blk_x_q) + TW'(1)) >= t_eff;
		blk_end = row_end && ((TW'(blk_y_q) + TW'(1)) >= t_eff);
	end

	// ------------------------------------------------------- frame clipping
	logic [FRAME_W-1:0]   w_eff, h_eff;
	logic signed [PW-1:0] px, py;
	logic                 in_frame;

	always_comb begin
		w_eff = (fw_q > FRAME_LIMIT) ? FRAME_LIMIT : fw_q;
		h_eff = (fh_q > FRAME_LIMIT) ? FRAME_LIMIT : fh_q;
		// brush pixel = line point + counter - half side
		px = PW'(cur_x_q) + $signed(PW'(blk_x_q)) - $signed(PW'(half));
		py = PW'(cur_y_q) + $signed(PW'(blk_y_q)) - $signed(PW'(half));
		in_frame = !px[PW-1] && !py[PW-1]
			&& (px < $signed(PW'(w_eff))) && (py < $signed(PW'(h_eff)));
	end

	// -------------------------------------------------------- bresenham step
	logic signed [EW:0]   e2;
	logic                 x_step, y_step, at_x, at_y, line_done;
	logic signed [EW-1:0] add_x, add_y, err_next;

	always_comb begin
		e2     = (EW + 1)'(err_q) <<< 1;
		x_step = e2 >= (EW + 1)'(ndy_q);
		y_step = e2 <= (EW + 1)'(dx_q);
		at_x   = (cur_x_q == goal_x_q);
		at_y   = (cur_y_q == goal_y_q);
		// the line ends on reaching the goal, or when a step is due along an
		// axis that already sits on its goal
		line_done = (at_x && at_y) || (x_step && at_x) || (y_step && at_y);
		add_x    = x_step ? EW'(ndy_q) : '0;
		add_y    = y_step ? EW'(dx_q) : '0;
		err_next = err_q + add_x + add_y;
	end

	// ------------------------------------------------------ start-line setup
	logic signed [DW-1:0] dx_s, dy_s, abs_dx, neg_dy;

	always_comb begin
		dx_s   = DW'(x_end) - DW'(x_start);
		dy_s   = DW'(y_end) - DW'(y_start);
		abs_dx = dx_s[DW-1] ? -dx_s : dx_s;
		neg_dy = dy_s[DW-1] ? dy_s : -dy_s;
	end

	// ----------------------------------------------------------- line state
	logic tick_live;
	assign tick_live = in_acc && !is_start && active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			blk_x_q  <= '0;
			blk_y_q  <= '0;
		end else if (in_acc && is_start) begin
			active_q <= 1'b1;
			blk_x_q  <= '0;
			blk_y_q  <= '0;
		end else if (tick_live) begin
			if (!row_end) begin
				blk_x_q <= blk_x_q + OFS_W'(1);
			end else if (!blk_end) begin
				blk_x_q <= '0;
				blk_y_q <= blk_y_q + OFS_W'(1);
			end else begin
				blk_x_q <= '0;
				blk_y_q <= '0;
				if (line_done)
					active_q <= 1'b0;
			end
		end
	end

	// geometry and color; once the line ends these are reloaded before use
	always_ff @(posedge clk) begin
		if (in_acc && is_start) begin
			cur_x_q  <= x_start;
			cur_y_q  <= y_start;
			goal_x_q <= x_end;
			goal_y_q <= y_end;
			dx_q     <= abs_dx;
			ndy_q    <= neg_dy;
			sx_q     <= !(x_start < x_end);
			sy_q     <= !(y_start < y_end);
			err_q    <= EW'(abs_dx) + EW'(neg_dy);
			red_q    <= color_red;
			green_q  <= color_green;
			blue_q   <= color_blue;
		end else if (tick_live && blk_end && !line_done) begin
			if (x_step)
				cur_x_q <= sx_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
			if (y_step)
				cur_y_q <= sy_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
			err_q <= err_next;
		end
	end

	// -------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= tick_live && in_frame;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_x_q   <= px[PIX_W-1:0];
			pixel_y_q   <= py[PIX_W-1:0];
			out_red_q   <= red_q;
			out_green_q <= green_q;
			out_blue_q  <= blue_q;
			last_q      <= blk_end && line_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign out_red    = out_red_q;
	assign out_green  = out_green_q;
	assign out_blue   = out_blue_q;
	assign last_pixel = last_q;

	// ------------------------------------------------------------- assertions
	// a start request always arms the line with a fresh brush
	`ASSERT_NEXT(a_start_arms, clk, arst_n, in_acc && is_start,
		active_q && blk_x_q == '0 && blk_y_q == '0)
	// the pixel flagged last is followed by an idle line
	`ASSERT_NEXT(a_last_ends_line, clk, arst_n, tick_live && blk_end && line_done,
		!active_q && out_valid_q == $past(in_frame))
	// brush counters never run past the largest side
	`ASSERT_SAME(a_brush_bounds, clk, arst_n, active_q,
		TW'(blk_x_q) < TW'(MAX_THICKNESS) && TW'(blk_y_q) < TW'(MAX_THICKNESS))

endmodule
`default_nettype wire

@@ test/thick_line_rasterizer_core_tb.sv @@
module thick_line_rasterizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import thlr_pkg::*;

	localparam int CW      = COORD_BITS_DEF;
	localparam int MAX_THK = MAX_THICKNESS_DEF;
	localparam int WIDE    = int'(FRAME_LIMIT);
	localparam int C_MIN   = -(1 << (CW - 1));
	localparam int C_MAX   = (1 << (CW - 1)) - 1;

	// one pixel write as it leaves the block
	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		logic               last_flag;
	} pixel_wr_t;

	// every block input has a known value from time zero
	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wr_en   = 1'b0;
	logic [IDX_W-1:0]          cfg_index   = '0;
	logic [CFG_W-1:0]          cfg_wr_data = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic                      opcode      = OP_TICK;
	logic signed [CW-1:0]      x_start     = '0;
	logic signed [CW-1:0]      y_start     = '0;
	logic signed [CW-1:0]      x_end       = '0;
	logic signed [CW-1:0]      y_end       = '0;
	logic [COLOR_W-1:0]        color_red   = '0;
	logic [COLOR_W-1:0]        color_green = '0;
	logic [COLOR_W-1:0]        color_blue  = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic [PIX_W-1:0]          pixel_x;
	logic [PIX_W-1:0]          pixel_y;
	logic [COLOR_W-1:0]        out_red;
	logic [COLOR_W-1:0]        out_green;
	logic [COLOR_W-1:0]        out_blue;
	logic                      last_pixel;

	thick_line_rasterizer_core i_dut (.*);

	// register copies as the block should hold them
	logic [THK_W-1:0]   m_thick  = THK_RESET;
	logic [FRAME_W-1:0] m_width  = FRAME_RESET;
	logic [FRAME_W-1:0] m_height = FRAME_RESET;

	// line walk state: current point, goal, bresenham terms, brush counters, color
	bit                 ln_active = 1'b0;
	int                 ln_x, ln_y, ln_gx, ln_gy;
	int                 ln_dx, ln_ndy, ln_err;
	bit                 ln_xdown, ln_ydown;
	int                 brush_x, brush_y;
	logic [COLOR_W-1:0] ln_r, ln_g, ln_b;

	// pixel writes still owed by the block, oldest first
	pixel_wr_t pixel_q[$];

	int n_fail     = 0;
	int n_items    = 0;
	int burst_left = 0;
	bit gaps_on    = 1'b0;
	bit stall_en   = 1'b0;
	int stall_pct  = 0;
	int stall_run  = 0;
	bit stall_now  = 1'b0;

	initial forever #6 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("thick_line_rasterizer_core regression: fail");
		$finish;
	end

	function automatic void note_fail(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t ns mismatch: %s", $realtime, msg);
	endfunction

	// thickness as the brush uses it: 0 acts as 1, large values saturate
	function automatic int eff_side();
		if (m_thick == 0)
			return 1;
		return (m_thick > MAX_THK) ? MAX_THK : int'(m_thick);
	endfunction

	// frames beyond the pixel range act as the full range
	function automatic int frame_lim(logic [FRAME_W-1:0] v);
		return (v > FRAME_LIMIT) ? WIDE : int'(v);
	endfunction

	function automatic int clamp_coord(int v);
		return (v < C_MIN) ? C_MIN : ((v > C_MAX) ? C_MAX : v);
	endfunction

	// start request: load endpoints and color, drop any line in progress
	function automatic void load_line(logic signed [CW-1:0] xs, ys, xe, ye,
			logic [COLOR_W-1:0] r, g, b);
		ln_x      = xs;
		ln_y      = ys;
		ln_gx     = xe;
		ln_gy     = ye;
		ln_dx     = (ln_gx > ln_x) ? ln_gx - ln_x : ln_x - ln_gx;
		ln_ndy    = (ln_gy > ln_y) ? ln_y - ln_gy : ln_gy - ln_y;
		ln_xdown  = !(ln_x < ln_gx);
		ln_ydown  = !(ln_y < ln_gy);
		ln_err    = ln_dx + ln_ndy;
		brush_x   = 0;
		brush_y   = 0;
		ln_r      = r;
		ln_g      = g;
		ln_b      = b;
		ln_active = 1'b1;
	endfunction

	// one bresenham step; zero once the line is over, including the early exits
	// where a step is asked for on an axis that already sits at its goal
	function automatic bit line_step();
		int twice;
		if (ln_x == ln_gx && ln_y == ln_gy)
			return 1'b0;
		twice = 2 * ln_err;
		if (twice >= ln_ndy) begin
			if (ln_x == ln_gx)
				return 1'b0;
			ln_err += ln_ndy;
			ln_x   += ln_xdown ? -1 : 1;
		end
		if (twice <= ln_dx) begin
			if (ln_y == ln_gy)
				return 1'b0;
			ln_err += ln_dx;
			ln_y   += ln_ydown ? -1 : 1;
		end
		return 1'b1;
	endfunction

	// tick request on an active line: next brush pixel, clipped to the frame
	function automatic void walk_brush();
		int side, w, h, px, py;
		bit row_end, blk_end, last_flag;
		side = eff_side();
		w    = frame_lim(m_width);
		h    = frame_lim(m_height);
		px   = ln_x + brush_x - side / 2;
		py   = ln_y + brush_y - side / 2;
		// counters left past a shrunken side close their row or block at once
		row_end   = brush_x + 1 >= side;
		blk_end   = row_end && (brush_y + 1 >= side);
		last_flag = 1'b0;
		if (!row_end) begin
			brush_x++;
		end else if (!blk_end) begin
			brush_x = 0;
			brush_y++;
		end else begin
			brush_x = 0;
			brush_y = 0;
			if (!line_step()) begin
				ln_active = 1'b0;
				last_flag = 1'b1;
			end
		end
		// off-frame pixels still advance the walk but write nothing
		if (px < 0 || py < 0 || px >= w || py >= h)
			return;
		pixel_q.push_back('{PIX_W'(px), PIX_W'(py), ln_r, ln_g, ln_b, last_flag});
	endfunction

	// receiver: runs of stall and go of random length
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(1, 12);
			stall_now = stall_en && ($urandom_range(0, 99) < stall_pct);
		end
		stall_run--;
		out_stall <= stall_now;
	end

	// every accepted pixel write against the oldest one owed
	always @(posedge clk) begin
		pixel_wr_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{pixel_x, pixel_y, out_red, out_green, out_blue, last_pixel};
			if (pixel_q.size() == 0) begin
				note_fail($sformatf("pixel write with none owed: x=%0d y=%0d last=%0b",
					got.x, got.y, got.last_flag));
			end else begin
				want = pixel_q.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.r !== want.r ||
						got.g !== want.g || got.b !== want.b ||
						got.last_flag !== want.last_flag)
					note_fail($sformatf({"expected x=%0d y=%0d rgb=%h_%h_%h last=%0b, ",
						"got x=%0d y=%0d rgb=%h_%h_%h last=%0b"},
						want.x, want.y, want.r, want.g, want.b, want.last_flag,
						got.x, got.y, got.r, got.g, got.b, got.last_flag));
			end
		end
	end

	// one request through the handshake; the sender idles between bursts if gaps_on is set
	task automatic send_req(input opcode_t op, input logic signed [CW-1:0] xs, ys, xe, ye,
			input logic [COLOR_W-1:0] r, g, b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		opcode      <= op;
		x_start     <= xs;
		y_start     <= ys;
		x_end       <= xe;
		y_end       <= ye;
		color_red   <= r;
		color_green <= g;
		color_blue  <= b;
		do @(posedge clk); while (in_stall);
		if (op == OP_START) begin
			load_line(xs, ys, xe, ye, r, g, b);
			n_items++;
		end else if (ln_active) begin
			walk_brush();
			n_items++;
		end
	endtask

	// tick with junk in the unused fields
	task automatic send_tick();
		send_req(OP_TICK, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
			COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
	endtask

	// hold off until every owed pixel has arrived, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// all three registers back to back; upper thickness data bits are junk or zero
	task automatic set_config(input logic [THK_W-1:0] thk, input logic [FRAME_W-1:0] w, h);
		logic [CFG_W-1:0] thk_word;
		thk_word = CFG_W'($urandom);
		if ($urandom_range(0, 1))
			thk_word[CFG_W-1:THK_W] = '0;
		thk_word[THK_W-1:0] = thk;
		cfg_wr_en   <= 1'b1;
		cfg_index   <= REG_LINE_THICKNESS;
		cfg_wr_data <= thk_word;
		@(posedge clk);
		cfg_index   <= REG_FRAME_WIDTH;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_index   <= REG_FRAME_HEIGHT;
		cfg_wr_data <= h;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		m_thick  = thk;
		m_width  = w;
		m_height = h;
	endtask

	// mostly inside the frame, some around its edges, a few anywhere
	function automatic int pick_coord(int lim, int side);
		int k;
		k = $urandom_range(0, 9);
		if (k < 6)
			return (lim == 0) ? 0 : int'($urandom_range(0, lim - 1));
		if (k < 8)
			return clamp_coord(($urandom_range(0, 1) ? lim : 0) +
				int'($urandom_range(0, 2 * side + 4)) - side - 2);
		return int'($urandom_range(0, C_MAX - C_MIN)) + C_MIN;
	endfunction

	// short line sized to the brush; either walked to its end or cut short
	task automatic draw_random_line(input bit complete);
		int side, reach, ax, ay, bx, by, n;
		side  = eff_side();
		reach = (side <= 2) ? 12 : ((side <= 4) ? 4 : ((side <= 8) ? 1 : 0));
		ax    = pick_coord(frame_lim(m_width), side);
		ay    = pick_coord(frame_lim(m_height), side);
		bx    = clamp_coord(ax + int'($urandom_range(0, 2 * reach)) - reach);
		by    = clamp_coord(ay + int'($urandom_range(0, 2 * reach)) - reach);
		send_req(OP_START, CW'(ax), CW'(ay), CW'(bx), CW'(by),
			COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
		if (complete) begin
			while (ln_active) send_tick();
			// a stray tick or two after the end is ignored
			repeat ($urandom_range(0, 2)) send_tick();
		end else begin
			n = $urandom_range(0, 3 * side * side);
			while (ln_active && n > 0) begin
				send_tick();
				n--;
			end
		end
	endtask

	// ticks with no line loaded give nothing
	task automatic test_idle_ticks();
		gaps_on  = 1'b0;
		stall_en = 1'b0;
		send_tick();
		send_tick();
	endtask

	// hand-picked lines under the reset registers
	task automatic test_reset_lines();
		// single-point line, then a tick once it is over
		send_req(OP_START, 0, 0, 0, 0, 8'hff, 8'h00, 8'hff);
		send_tick();
		send_tick();
		// corner to corner, mostly off frame, abandoned by the next start
		send_req(OP_START, -4096, -4096, 4095, 4095, 8'h00, 8'hff, 8'h00);
		repeat (3) send_tick();
		send_req(OP_START, 4095, 4095, -4096, -4096, 8'h5a, 8'ha5, 8'h3c);
		repeat (2) send_tick();
		stall_en  = 1'b1;
		stall_pct = 50;
		// shallow and steep lines in two directions
		send_req(OP_START, 3, 5, 6, 3, 8'h12, 8'h34, 8'h56);
		while (ln_active) send_tick();
		send_req(OP_START, 10, 2, 7, 9, 8'h80, 8'h7f, 8'h01);
		while (ln_active) send_tick();
		// line ends past the right edge, so no write carries the last flag
		send_req(OP_START, 510, 100, 512, 101, 8'hc3, 8'h3c, 8'h99);
		while (ln_active) send_tick();
	endtask

	// brush shrinks while its counters sit beyond the new side
	task automatic test_midline_thickness();
		drain();
		set_config(3, FRAME_RESET, FRAME_RESET);
		send_req(OP_START, 20, 20, 21, 20, 8'hee, 8'h11, 8'h77);
		repeat (5) send_tick();
		drain();
		set_config(1, FRAME_RESET, FRAME_RESET);
		while (ln_active) send_tick();
	endtask

	// phases of register settings, extremes first, then random ones
	task automatic test_random_lines();
		logic [THK_W-1:0]   thk;
		logic [FRAME_W-1:0] w, h;
		int                 budget, pick;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin thk = 1;  w = 512;  h = 512;  end
				1: begin thk = 16; w = 4096; h = 4096; end
				2: begin thk = 0;  w = 1;    h = 1;    end
				3: begin thk = 31; w = 8191; h = 8191; end
				4: begin thk = 2;  w = 16;   h = 16;   end
				5: begin thk = 4;  w = 0;    h = 300;  end
				6: begin thk = 3;  w = 4096; h = 64;   end
				default: begin
					thk = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom_range(6, 31);
					w   = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4096) :
						$urandom_range(4097, 8191);
					h   = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4096) :
						$urandom_range(4097, 8191);
				end
			endcase
			drain();
			set_config(thk, w, h);
			gaps_on   = $urandom_range(0, 9) < 7;
			stall_en  = $urandom_range(0, 9) < 7;
			stall_pct = $urandom_range(10, 60);
			// a wide brush overshoots by most of one line, so it gets the larger budget
			budget    = n_items + ((eff_side() > 8) ? 200 : 70);
			while (n_items < budget) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					send_tick();
				else if (pick < 9)
					drain();
				else
					draw_random_line(pick >= 20);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_reset_lines();
		test_midline_thickness();
		test_random_lines();
		drain();
		repeat (8) @(posedge clk);
		if (n_fail == 0 && pixel_q.size() == 0)
			$display("thick_line_rasterizer_core regression: pass");
		else
			$display("thick_line_rasterizer_core regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/thlr_pkg.sv
rtl/thick_line_rasterizer_core.sv
test/thick_line_rasterizer_core_tb.sv
